### src/eac_pkg.sv
// Shared constants for the epicycle arm chain: field widths, register codes and reset values.
`timescale 1ns / 1ps

package eac_pkg;

    // Phase and geometry widths
    localparam int PHASE_W    = 32;
    localparam int SCALE_W    = 24;
    localparam int LEN_W      = 10;
    localparam int SPEED_W    = 8;
    localparam int INIT_W     = 16;
    localparam int CENTER_W   = 12;
    localparam int ACTIVE_W   = 3;
    localparam int COORD_W    = 14;
    localparam int SINE_W     = 16;
    localparam int MAG_W      = SINE_W - 1;
    localparam int PROD_W     = LEN_W + MAG_W;
    localparam int OFF_W      = LEN_W + 1;
    localparam int ROUND_SHIFT = 15;

    // Arm register layout
    localparam int ARM_CFG_W  = 34;
    localparam int LEN_LSB    = 0;
    localparam int SPEED_LSB  = 10;
    localparam int INIT_LSB   = 18;
    localparam int ARM_REGS   = 4;
    localparam int ARM_SEL_W  = 2;
    localparam int MAX_EMIT   = 4;
    localparam int ARM_NUM_W  = 4;
    localparam int ARM_OUT_W  = 2;

    // A quarter turn turns a sine lookup into a cosine lookup.
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;

    // Stream layout
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 1;
    localparam int OUT_TDATA_W = 64;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (ARM_OUT_W + 4 * COORD_W);

    // Request kinds carried in tuser
    localparam logic MODE_TICK    = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_3    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE   = 3'd6;

    // Register reset values
    localparam logic [ARM_CFG_W-1:0] ARM_0_RST = 34'd8202749128;
    localparam logic [ARM_CFG_W-1:0] ARM_1_RST = 34'd260196;
    localparam logic [ARM_CFG_W-1:0] ARM_2_RST = 34'd259122;
    localparam logic [ARM_CFG_W-1:0] ARM_3_RST = 34'd258058;
    localparam logic [CENTER_W-1:0]  CENTER_X_RST = 12'd1280;
    localparam logic [CENTER_W-1:0]  CENTER_Y_RST = 12'd720;
    localparam logic [ACTIVE_W-1:0]  ACTIVE_RST   = 3'd4;

endpackage

### src/eac_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module eac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds while the read is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/eac_sine_rom.sv
// Q1.15 sine table with two registered read ports, built at elaboration.
`timescale 1ns / 1ps

module eac_sine_rom #(
    parameter int ENTRIES = 1024
) (
    input  logic                                      i_clk,
    input  logic                                      i_en,
    input  logic [$clog2(ENTRIES)-1:0]                i_addr_a,
    input  logic [$clog2(ENTRIES)-1:0]                i_addr_b,
    output logic signed [eac_pkg::SINE_W-1:0]         o_data_a,
    output logic signed [eac_pkg::SINE_W-1:0]         o_data_b
);

    import eac_pkg::*;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned ONE_Q30     = 64'd1073741824;
    localparam longint unsigned ENTRIES_U   = 64'(ENTRIES);
    localparam int SERIES_TERMS = 12;

    // Taylor divisors k*(k+1) for the sine and cosine series.
    localparam longint unsigned SIN_DIV [SERIES_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
          64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600};
    localparam longint unsigned COS_DIV [SERIES_TERMS] =
        '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
          64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552};

    // Restoring long division, only evaluated while the table is built.
    function automatic longint unsigned div_u64(input longint unsigned num,
                                                input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = 64'd0;
        rem = 64'd0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Entry k: the quadrant series in Q30, clamped, scaled to Q1.15 with rounding.
    function automatic logic signed [SINE_W-1:0] sine_entry(input int unsigned k);
        longint unsigned q;
        longint unsigned r;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint unsigned m;
        longint          v;
        logic            cosine;
        q = div_u64(64'(k) * 64'd4, ENTRIES_U);
        r = 64'(k) * 64'd4 - q * ENTRIES_U;
        a = div_u64(HALF_PI_Q30 * r, ENTRIES_U);
        cosine = q[0];
        a2 = (a * a) >> 30;
        term = cosine ? ONE_Q30 : a;
        v = longint'(term);
        for (int i = 0; i < SERIES_TERMS; i++) begin
            term = div_u64((term * a2) >> 30, cosine ? COS_DIV[i] : SIN_DIV[i]);
            if (i[0]) begin
                v = v + longint'(term);
            end else begin
                v = v - longint'(term);
            end
        end
        if (v < 0) begin
            v = 0;
        end
        if (v > longint'(ONE_Q30)) begin
            v = longint'(ONE_Q30);
        end
        m = (longint'(v) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
        return (q >= 64'd2) ? -SINE_W'(m) : SINE_W'(m);
    endfunction

    logic signed [SINE_W-1:0] sine_tbl [ENTRIES];
    logic signed [SINE_W-1:0] r_data_a;
    logic signed [SINE_W-1:0] r_data_b;

    // Constant contents, one elaboration-time value per entry.
    for (genvar k = 0; k < ENTRIES; k++) begin : g_entry
        localparam logic signed [SINE_W-1:0] VAL = sine_entry(k);
        assign sine_tbl[k] = VAL;
    end

    // Two registered read ports that hold while not enabled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data_a <= sine_tbl[i_addr_a];
            r_data_b <= sine_tbl[i_addr_b];
        end
    end

    assign o_data_a = r_data_a;
    assign o_data_b = r_data_b;

endmodule

### src/epicycle_arm_chain_core.sv
// Epicycle arm chain core: phases in a RAM, walked arm by arm through a short pipeline.
// Each arm passes stage 1 (phase RAM read), stage 2 (phase update), stage 3 (table lookup),
// stage 4 (offsets) and the output register; segments leave one per cycle unless the output stalls.
// A new request waits for the single read-modify-write pass over the phase RAM, one arm per advancing cycle.
// Reset (synchronous, active low) loads the register defaults and marks every phase as zero
// through per-arm valid bits; there is no clearing pass and no wait after reset.
`timescale 1ns / 1ps

module epicycle_arm_chain_core #(
    parameter int NUM_ARMS           = 4,
    parameter int SINE_TABLE_ENTRIES = 1024
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Requests
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [eac_pkg::IN_TDATA_W-1:0]       s_axis_tdata,  // [23:0] step_scale
    input  logic [eac_pkg::IN_TUSER_W-1:0]       s_axis_tuser,  // [0] mode
    // Segments
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [1:0] arm_index, [15:2] start_x, [29:16] start_y, [43:30] end_x, [57:44] end_y,
    // [63:58] zero
    output logic [eac_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                                 m_axis_tlast,
    // Configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [eac_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [eac_pkg::ARM_CFG_W-1:0]        i_cfg_data
);

    import eac_pkg::*;

    localparam int AIW = (NUM_ARMS > 1) ? $clog2(NUM_ARMS) : 1;
    localparam int SAW = $clog2(SINE_TABLE_ENTRIES);
    localparam int IPW = PHASE_W + SAW;
    localparam int CAP = (NUM_ARMS < MAX_EMIT) ? NUM_ARMS : MAX_EMIT;
    localparam logic [AIW-1:0]      LAST_ARM = AIW'(NUM_ARMS - 1);
    localparam logic [ACTIVE_W-1:0] CAP_CNT  = ACTIVE_W'(CAP);

    // Configuration registers
    logic [ARM_CFG_W-1:0] r_arm_cfg [ARM_REGS];
    logic [CENTER_W-1:0]  r_cx;
    logic [CENTER_W-1:0]  r_cy;
    logic [ACTIVE_W-1:0]  r_active;

    // Request capture and arm sequencer
    logic                 r_busy;
    logic [AIW-1:0]       r_arm;
    logic                 r_mode;
    logic [SCALE_W-1:0]   r_scale;
    logic [ACTIVE_W-1:0]  r_count;
    logic [ACTIVE_W-1:0]  n_count;
    logic                 in_acc;
    logic                 issue;
    logic                 adv;

    // Issue-stage decode
    logic [ARM_NUM_W-1:0] arm_w;
    logic [ARM_CFG_W-1:0] arm_sel;
    logic                 is_restart;
    logic signed [PHASE_W:0] step_full;

    // Stage 1: phase RAM read in flight
    logic                 r_s1_vld;
    logic [ARM_NUM_W-1:0] r_s1_arm;
    logic                 r_s1_restart;
    logic                 r_s1_emit;
    logic                 r_s1_last;
    logic [INIT_W-1:0]    r_s1_init;
    logic [LEN_W-1:0]     r_s1_len;
    logic [PHASE_W-1:0]   r_s1_step;

    // Phase RAM and its valid bits
    logic [PHASE_W-1:0]   ram_rdata;
    logic                 ram_we;
    logic [PHASE_W-1:0]   old_phase;
    logic [PHASE_W-1:0]   n_phase;
    logic [NUM_ARMS-1:0]  r_ph_vld;

    // Stage 2: updated phase
    logic                 r_s2_vld;
    logic [ARM_NUM_W-1:0] r_s2_arm;
    logic                 r_s2_last;
    logic [LEN_W-1:0]     r_s2_len;
    logic [PHASE_W-1:0]   r_s2_phase;

    // Table index computation
    logic [PHASE_W-1:0]   cos_phase;
    logic [IPW-1:0]       sin_prod;
    logic [IPW-1:0]       cos_prod;
    logic [SAW-1:0]       sin_idx;
    logic [SAW-1:0]       cos_idx;

    // Stage 3: table lookup in flight
    logic                 r_s3_vld;
    logic [ARM_NUM_W-1:0] r_s3_arm;
    logic                 r_s3_last;
    logic [LEN_W-1:0]     r_s3_len;
    logic signed [SINE_W-1:0] rom_sin;
    logic signed [SINE_W-1:0] rom_cos;

    // Offset arithmetic
    logic signed [SINE_W-1:0] neg_sin;
    logic signed [SINE_W-1:0] neg_cos;
    logic [MAG_W-1:0]     mag_x;
    logic [MAG_W-1:0]     mag_y;
    logic [PROD_W-1:0]    rnd_x;
    logic [PROD_W-1:0]    rnd_y;
    logic [LEN_W-1:0]     dx;
    logic [LEN_W-1:0]     dy;
    logic signed [OFF_W-1:0] off_x;
    logic signed [OFF_W-1:0] off_y;

    // Stage 4: offsets ready
    logic                 r_s4_vld;
    logic [ARM_NUM_W-1:0] r_s4_arm;
    logic                 r_s4_last;
    logic signed [OFF_W-1:0] r_s4_offx;
    logic signed [OFF_W-1:0] r_s4_offy;

    // Chain and output register
    logic [COORD_W-1:0]   start_x;
    logic [COORD_W-1:0]   start_y;
    logic [COORD_W-1:0]   end_x;
    logic [COORD_W-1:0]   end_y;
    logic [COORD_W-1:0]   r_chain_x;
    logic [COORD_W-1:0]   r_chain_y;
    logic                 r_out_vld;
    logic [ARM_OUT_W-1:0] r_out_arm;
    logic [COORD_W-1:0]   r_out_sx;
    logic [COORD_W-1:0]   r_out_sy;
    logic [COORD_W-1:0]   r_out_ex;
    logic [COORD_W-1:0]   r_out_ey;
    logic                 r_out_last;

    // Configuration writes; indexes past the list are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_cfg[0] <= ARM_0_RST;
            r_arm_cfg[1] <= ARM_1_RST;
            r_arm_cfg[2] <= ARM_2_RST;
            r_arm_cfg[3] <= ARM_3_RST;
            r_cx         <= CENTER_X_RST;
            r_cy         <= CENTER_Y_RST;
            r_active     <= ACTIVE_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_ARM_0:    r_arm_cfg[0] <= i_cfg_data;
                CFG_ARM_1:    r_arm_cfg[1] <= i_cfg_data;
                CFG_ARM_2:    r_arm_cfg[2] <= i_cfg_data;
                CFG_ARM_3:    r_arm_cfg[3] <= i_cfg_data;
                CFG_CENTER_X: r_cx         <= i_cfg_data[CENTER_W-1:0];
                CFG_CENTER_Y: r_cy         <= i_cfg_data[CENTER_W-1:0];
                CFG_ACTIVE:   r_active     <= i_cfg_data[ACTIVE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The whole pipeline moves only when the output register can take a segment.
    assign adv = !r_out_vld || m_axis_tready;

    // With a single arm the next read would hit the entry still being written back.
    assign s_axis_tready = !r_busy && !((NUM_ARMS == 1) && r_s1_vld);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign issue         = r_busy && adv;

    // Number of segments a tick emits: zero counts as one, capped at the smaller of the arm count and the emit limit.
    always_comb begin
        if (r_active == '0) begin
            n_count = ACTIVE_W'(1);
        end else if (r_active > CAP_CNT) begin
            n_count = CAP_CNT;
        end else begin
            n_count = r_active;
        end
    end

    // Arm sequencer: one arm issued per advancing cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_arm  <= '0;
        end else if (in_acc) begin
            r_busy <= 1'b1;
            r_arm  <= '0;
        end else if (issue) begin
            if (r_arm == LAST_ARM) begin
                r_busy <= 1'b0;
            end else begin
                r_arm <= r_arm + AIW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mode  <= s_axis_tuser[0];
            r_scale <= s_axis_tdata[SCALE_W-1:0];
            r_count <= n_count;
        end
    end

    // Issue decode: arms without a register have zero length, speed and phase.
    assign arm_w      = ARM_NUM_W'(r_arm);
    assign arm_sel    = (arm_w < ARM_NUM_W'(ARM_REGS)) ? r_arm_cfg[arm_w[ARM_SEL_W-1:0]] : '0;
    assign is_restart = (r_mode == MODE_RESTART);
    assign step_full  = $signed(arm_sel[SPEED_LSB +: SPEED_W]) * $signed({1'b0, r_scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (adv) begin
            r_s1_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_arm     <= arm_w;
            r_s1_restart <= is_restart;
            r_s1_emit    <= !is_restart && (arm_w < ARM_NUM_W'(r_count));
            r_s1_last    <= !is_restart && (arm_w == ARM_NUM_W'(r_count) - ARM_NUM_W'(1));
            r_s1_init    <= arm_sel[INIT_LSB +: INIT_W];
            r_s1_len     <= arm_sel[LEN_LSB +: LEN_W];
            r_s1_step    <= step_full[PHASE_W-1:0];
        end
    end

    // Phase RAM: read at issue, written back from stage 1 when the pipeline next advances.
    assign ram_we = r_s1_vld && adv;

    eac_ram #(
        .WIDTH (PHASE_W),
        .DEPTH (NUM_ARMS)
    ) u_phase_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_arm[AIW-1:0]),
        .i_wdata (n_phase),
        .i_re    (adv),
        .i_raddr (r_arm),
        .o_rdata (ram_rdata)
    );

    // Read-modify-write: restart reloads the phase, a tick adds the step.
    assign old_phase = r_ph_vld[r_s1_arm[AIW-1:0]] ? ram_rdata : '0;
    assign n_phase   = r_s1_restart ? {r_s1_init, {(PHASE_W - INIT_W){1'b0}}}
                                    : old_phase + r_s1_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph_vld <= '0;
        end else if (ram_we) begin
            r_ph_vld[r_s1_arm[AIW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (adv) begin
            r_s2_vld <= r_s1_vld && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_arm   <= r_s1_arm;
            r_s2_last  <= r_s1_last;
            r_s2_len   <= r_s1_len;
            r_s2_phase <= n_phase;
        end
    end

    // Table index is floor(phase * entries / 2^32); cosine reads a quarter turn ahead.
    assign cos_phase = r_s2_phase + QUARTER_TURN;
    assign sin_prod  = IPW'(r_s2_phase) * IPW'(SINE_TABLE_ENTRIES);
    assign cos_prod  = IPW'(cos_phase) * IPW'(SINE_TABLE_ENTRIES);
    assign sin_idx   = sin_prod[PHASE_W +: SAW];
    assign cos_idx   = cos_prod[PHASE_W +: SAW];

    eac_sine_rom #(
        .ENTRIES (SINE_TABLE_ENTRIES)
    ) u_sine_rom (
        .i_clk    (i_clk),
        .i_en     (adv),
        .i_addr_a (sin_idx),
        .i_addr_b (cos_idx),
        .o_data_a (rom_sin),
        .o_data_b (rom_cos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else if (adv) begin
            r_s3_vld <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_arm  <= r_s2_arm;
            r_s3_last <= r_s2_last;
            r_s3_len  <= r_s2_len;
        end
    end

    // Offsets: round(len * |s| / 2^15) with the sign of s.
    assign neg_sin = -rom_sin;
    assign neg_cos = -rom_cos;
    assign mag_x   = rom_cos[SINE_W-1] ? neg_cos[MAG_W-1:0] : rom_cos[MAG_W-1:0];
    assign mag_y   = rom_sin[SINE_W-1] ? neg_sin[MAG_W-1:0] : rom_sin[MAG_W-1:0];
    assign rnd_x   = PROD_W'(r_s3_len) * PROD_W'(mag_x) + PROD_W'(1 << (ROUND_SHIFT - 1));
    assign rnd_y   = PROD_W'(r_s3_len) * PROD_W'(mag_y) + PROD_W'(1 << (ROUND_SHIFT - 1));
    assign dx      = rnd_x[ROUND_SHIFT +: LEN_W];
    assign dy      = rnd_y[ROUND_SHIFT +: LEN_W];
    assign off_x   = rom_cos[SINE_W-1] ? -$signed({1'b0, dx}) : $signed({1'b0, dx});
    assign off_y   = rom_sin[SINE_W-1] ? -$signed({1'b0, dy}) : $signed({1'b0, dy});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else if (adv) begin
            r_s4_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_arm  <= r_s3_arm;
            r_s4_last <= r_s3_last;
            r_s4_offx <= off_x;
            r_s4_offy <= off_y;
        end
    end

    // The first arm starts at the center, each later arm at the previous end.
    assign start_x = (r_s4_arm == '0) ? COORD_W'(r_cx) : r_chain_x;
    assign start_y = (r_s4_arm == '0) ? COORD_W'(r_cy) : r_chain_y;
    assign end_x   = start_x + {{(COORD_W - OFF_W){r_s4_offx[OFF_W-1]}}, r_s4_offx};
    assign end_y   = start_y + {{(COORD_W - OFF_W){r_s4_offy[OFF_W-1]}}, r_s4_offy};

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_s4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s4_vld) begin
            r_out_arm  <= r_s4_arm[ARM_OUT_W-1:0];
            r_out_sx   <= start_x;
            r_out_sy   <= start_y;
            r_out_ex   <= end_x;
            r_out_ey   <= end_y;
            r_out_last <= r_s4_last;
            r_chain_x  <= end_x;
            r_chain_y  <= end_y;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out_ey, r_out_ex, r_out_sy, r_out_sx, r_out_arm};

endmodule

### src/eac_checker.sv
// Port-level assertions for the epicycle arm chain core, bound to the top level.
`timescale 1ns / 1ps

module eac_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [eac_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tlast
);

    import eac_pkg::*;

    // A stalled segment stays on the bus unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("segment changed while stalled");

    // Ready drops right after a request is taken, so no second one is taken while its arms issue.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while one is in work");

    // The highest arm index that can be emitted always closes the tick.
    a_top_arm_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[ARM_OUT_W-1:0] == ARM_OUT_W'(MAX_EMIT - 1))
            |-> m_axis_tlast)
        else $error("segment of the top arm not flagged as last");

    // Reset empties the output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("segment valid after reset");

endmodule

bind epicycle_arm_chain_core eac_checker u_eac_checker (.*);

### dv/tb_epicycle_arm_chain_core.sv
// Self-checking testbench for the epicycle arm chain core: segment prediction and streaming checks.
`timescale 1ns / 1ps

module tb_epicycle_arm_chain_core;

    import eac_pkg::*;

    localparam int ARMS         = 4;
    localparam int SINE_ENTRIES = 1024;
    localparam int CLK_HALF     = 4;
    localparam int DRAIN_PAUSE  = 12;
    localparam int STALL_CYCLES = 400;
    localparam int BLOCKS       = 12;
    localparam int BLOCK_ITEMS  = 37;
    // The register map leaves index 7 unused; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // One drawn segment, with coordinates kept at the output width.
    typedef struct packed {
        logic [ARM_OUT_W-1:0] arm;
        logic [COORD_W-1:0]   start_x;
        logic [COORD_W-1:0]   start_y;
        logic [COORD_W-1:0]   end_x;
        logic [COORD_W-1:0]   end_y;
        logic                 last;
    } t_arm_segment;

    // Tracks arm phases and registers, predicts the segments of each tick and checks them.
    class arm_chain_scoreboard;
        logic [ARM_CFG_W-1:0] arm_reg [ARMS];
        logic [CENTER_W-1:0]  center_x;
        logic [CENTER_W-1:0]  center_y;
        logic [ACTIVE_W-1:0]  active_arms;
        logic [PHASE_W-1:0]   arm_phase [ARMS];
        int                   sine_q15 [SINE_ENTRIES];
        t_arm_segment         expected_segments [$];
        int                   errors;
        int                   ticks;
        int                   restarts;
        int                   segments;

        function new();
            arm_reg[0]  = ARM_0_RST;
            arm_reg[1]  = ARM_1_RST;
            arm_reg[2]  = ARM_2_RST;
            arm_reg[3]  = ARM_3_RST;
            center_x    = CENTER_X_RST;
            center_y    = CENTER_Y_RST;
            active_arms = ACTIVE_RST;
            for (int i = 0; i < ARMS; i++) arm_phase[i] = '0;
            errors   = 0;
            ticks    = 0;
            restarts = 0;
            segments = 0;
            build_sine_table();
        endfunction

        // Taylor series in Q30 over one quadrant, sine or cosine.
        function longint quadrant_series(longint unsigned a, bit use_cos);
            longint unsigned a2;
            longint unsigned term;
            longint unsigned div;
            longint          sum;
            a2   = (a * a) >> 30;
            term = use_cos ? 64'd1073741824 : a;
            div  = use_cos ? 64'd1 : 64'd2;
            sum  = longint'(term);
            for (int i = 0; i < 12; i++) begin
                term = ((term * a2) >> 30) / (div * (div + 64'd1));
                div += 64'd2;
                if (i % 2 == 1) begin
                    sum += longint'(term);
                end else begin
                    sum -= longint'(term);
                end
            end
            return sum;
        endfunction

        // Q1.15 sine table; odd quadrants use the cosine series, the lower half is negated.
        function void build_sine_table();
            longint unsigned q;
            longint unsigned r;
            longint unsigned a;
            longint          v;
            longint          m;
            for (int k = 0; k < SINE_ENTRIES; k++) begin
                q = (64'd4 * k) / SINE_ENTRIES;
                r = 64'd4 * k - q * SINE_ENTRIES;
                a = 64'd1686629713 * r / SINE_ENTRIES;
                v = quadrant_series(a, q[0]);
                if (v < 0) v = 0;
                if (v > 64'sd1073741824) v = 64'sd1073741824;
                m = (v * 32767 + 64'sd536870912) >>> 30;
                sine_q15[k] = (q >= 2) ? -int'(m) : int'(m);
            end
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [ARM_CFG_W-1:0] data);
            case (idx)
                CFG_ARM_0, CFG_ARM_1, CFG_ARM_2, CFG_ARM_3: begin
                    arm_reg[idx[ARM_SEL_W-1:0]] = data;
                end
                CFG_CENTER_X: begin
                    center_x = data[CENTER_W-1:0];
                end
                CFG_CENTER_Y: begin
                    center_y = data[CENTER_W-1:0];
                end
                CFG_ACTIVE: begin
                    active_arms = data[ACTIVE_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        // Rounded length times a Q1.15 sample, sign kept apart from the rounding.
        function int arm_offset(int len, int s);
            int mag;
            int d;
            mag = (s < 0) ? -s : s;
            d   = (len * mag + 16384) >>> 15;
            return (s < 0) ? -d : d;
        endfunction

        // Advance or reload the phases, then queue the segments of a tick.
        function void note_request(logic mode, logic [SCALE_W-1:0] scale);
            logic signed [SPEED_W-1:0] speed;
            longint                    step;
            logic [PHASE_W-1:0]        cos_phase;
            int                        count;
            int                        sx;
            int                        sy;
            int                        ex;
            int                        ey;
            int                        len;
            t_arm_segment              seg;
            if (mode == MODE_RESTART) begin
                for (int i = 0; i < ARMS; i++) begin
                    arm_phase[i] = {arm_reg[i][INIT_LSB +: INIT_W], 16'h0000};
                end
                restarts++;
                return;
            end
            ticks++;
            for (int i = 0; i < ARMS; i++) begin
                speed = arm_reg[i][SPEED_LSB +: SPEED_W];
                step  = longint'(speed) * longint'(scale);
                arm_phase[i] += step[PHASE_W-1:0];
            end
            count = int'(active_arms);
            if (count < 1) count = 1;
            if (count > ARMS) count = ARMS;
            sx = int'(center_x);
            sy = int'(center_y);
            for (int i = 0; i < count; i++) begin
                len       = int'(arm_reg[i][LEN_LSB +: LEN_W]);
                cos_phase = arm_phase[i] + QUARTER_TURN;
                ex = sx + arm_offset(len, sine_q15[cos_phase[PHASE_W-1 -: 10]]);
                ey = sy + arm_offset(len, sine_q15[arm_phase[i][PHASE_W-1 -: 10]]);
                seg.arm     = i[ARM_OUT_W-1:0];
                seg.start_x = sx[COORD_W-1:0];
                seg.start_y = sy[COORD_W-1:0];
                seg.end_x   = ex[COORD_W-1:0];
                seg.end_y   = ey[COORD_W-1:0];
                seg.last    = (i == count - 1);
                expected_segments.push_back(seg);
                sx = ex;
                sy = ey;
            end
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $display("%0t: segment %s mismatch, expected %0d actual %0d",
                         $time, name, want, got);
                errors++;
            end
        endfunction

        // Unpack one accepted segment and compare it with the oldest prediction.
        function void check_segment(logic [OUT_TDATA_W-1:0] data, logic tlast);
            t_arm_segment want;
            if (expected_segments.size() == 0) begin
                $display("%0t: unexpected segment, expected none actual %h last %0b",
                         $time, data, tlast);
                errors++;
                return;
            end
            want = expected_segments.pop_front();
            segments++;
            compare_field("arm_index", want.arm, data[1:0]);
            compare_field("start_x", $signed(want.start_x), $signed(data[15:2]));
            compare_field("start_y", $signed(want.start_y), $signed(data[29:16]));
            compare_field("end_x", $signed(want.end_x), $signed(data[43:30]));
            compare_field("end_y", $signed(want.end_y), $signed(data[57:44]));
            compare_field("last", want.last, tlast);
            compare_field("padding", 0, data[OUT_TDATA_W-1:58]);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tlast;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [ARM_CFG_W-1:0]   i_cfg_data = '0;

    arm_chain_scoreboard sb;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int stall_request = 0;
    int stall_left = 0;
    int cfg_writes = 0;

    epicycle_arm_chain_core #(
        .NUM_ARMS          (ARMS),
        .SINE_TABLE_ENTRIES(SINE_ENTRIES)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Segment receiver: random back-pressure, plus a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_request > 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // Every accepted segment is checked at the edge that moves it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_segment(m_axis_tdata, m_axis_tlast);
        end
    end

    // Offer one request after a random gap and wait for it to be taken.
    task automatic send_request(input logic mode, input logic [SCALE_W-1:0] scale);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= scale;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_request(mode, scale);
        @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [ARM_CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_register(idx, data);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop offering requests and let every predicted segment and any restart finish.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_segments.size() != 0) @(negedge i_clk);
        repeat (DRAIN_PAUSE) @(negedge i_clk);
    endtask

    function automatic logic [ARM_CFG_W-1:0] random_word();
        return {2'($urandom_range(0, 3)), $urandom()};
    endfunction

    function automatic logic [SCALE_W-1:0] random_scale();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3, 4: return SCALE_W'($urandom_range(0, 255));
            default: return SCALE_W'($urandom());
        endcase
    endfunction

    // New random settings for every register; the active count covers 0 to 7.
    task automatic randomize_config();
        write_register(CFG_ARM_0, random_word());
        write_register(CFG_ARM_1, random_word());
        write_register(CFG_ARM_2, random_word());
        write_register(CFG_ARM_3, random_word());
        write_register(CFG_CENTER_X, random_word());
        write_register(CFG_CENTER_Y, random_word());
        write_register(CFG_ACTIVE, random_word());
        if ($urandom_range(0, 2) == 0) write_register(CFG_UNUSED, random_word());
    endtask

    // Run limit, well above the slowest legal run.
    initial begin
        #(4_000_000);
        $display("Timeout: segments still outstanding or requests not accepted.");
        $display("Regression FAIL");
        $finish;
    end

    // Main sequence: reset, directed cases, then random blocks under three idling profiles.
    initial begin
        sb = new();
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        tx_idle_pct = 28;
        rx_idle_pct = 73;

        // Defaults, with phases still zero before the first restart.
        send_request(MODE_TICK, 24'h123456);
        send_request(MODE_RESTART, 24'h000000);
        send_request(MODE_TICK, 24'h000000);
        send_request(MODE_TICK, 24'hFFFFFF);
        send_request(MODE_TICK, 24'h000001);
        wait_idle();

        // Longest arms, extreme speeds, far corner; active count above the cap.
        write_register(CFG_ARM_0, 34'h3_FFFF_FFFF);
        write_register(CFG_ARM_1, {16'h0000, 8'h7F, 10'h3FF});
        write_register(CFG_ARM_2, {16'h8000, 8'h80, 10'h3FF});
        write_register(CFG_ARM_3, {16'h4000, 8'h01, 10'h000});
        write_register(CFG_CENTER_X, 34'd4095);
        write_register(CFG_CENTER_Y, 34'd4095);
        write_register(CFG_ACTIVE, 34'd7);
        send_request(MODE_TICK, 24'hFFFFFF);
        send_request(MODE_RESTART, 24'hFFFFFF);
        send_request(MODE_TICK, 24'hFFFFFF);
        send_request(MODE_TICK, 24'h800000);
        wait_idle();

        // Origin center drives coordinates negative; an active count of zero means one arm.
        write_register(CFG_CENTER_X, 34'd0);
        write_register(CFG_CENTER_Y, 34'd0);
        write_register(CFG_ACTIVE, 34'd0);
        send_request(MODE_TICK, 24'h000001);
        send_request(MODE_RESTART, 24'h000000);
        send_request(MODE_TICK, 24'hFFFFFF);
        wait_idle();

        // Upper register bits are dropped; the unused index is ignored.
        write_register(CFG_ACTIVE, 34'h3_FFFF_FFFC);
        write_register(CFG_CENTER_X, 34'h2_AAAA_A800);
        write_register(CFG_CENTER_Y, 34'h1_5555_53FF);
        write_register(CFG_UNUSED, 34'h3_FFFF_FFFF);
        send_request(MODE_RESTART, 24'hABCDEF);
        send_request(MODE_TICK, 24'h400000);
        send_request(MODE_TICK, 24'hABCDEF);
        wait_idle();

        write_register(CFG_ACTIVE, 34'd2);
        send_request(MODE_TICK, 24'h00FF00);
        wait_idle();
        write_register(CFG_ACTIVE, 34'd3);
        send_request(MODE_TICK, 24'h0F0F0F);
        wait_idle();
        write_register(CFG_ACTIVE, 34'd1);
        send_request(MODE_TICK, 24'h7FFFFF);
        wait_idle();

        // Random blocks; idling profile changes every four blocks.
        for (int blk = 0; blk < BLOCKS; blk++) begin
            case (blk / 4)
                0: begin
                    tx_idle_pct = 28;
                    rx_idle_pct = 73;
                end
                1: begin
                    tx_idle_pct = 73;
                    rx_idle_pct = 28;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            randomize_config();
            // In block 9, fill the block while the receiver holds off for a long stretch.
            if (blk == 9) stall_request = STALL_CYCLES;
            if (blk % 2 == 0) send_request(MODE_RESTART, random_scale());
            for (int n = 0; n < BLOCK_ITEMS; n++) begin
                if ($urandom_range(0, 99) < 8) begin
                    send_request(MODE_RESTART, random_scale());
                end else begin
                    send_request(MODE_TICK, random_scale());
                end
            end
            wait_idle();
        end

        repeat (DRAIN_PAUSE) @(negedge i_clk);
        $display("Covered %0d ticks, %0d restarts, %0d segments, %0d register writes.",
                 sb.ticks, sb.restarts, sb.segments, cfg_writes);
        $display("Active counts 0 to 7, extreme arms and centers, three idling profiles, "
                 , "one long output stall.");
        if (sb.errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
